@@ rtl/sgm_pkg.sv @@
// sobel gradient magnitude: shared types and constants
// no dependencies
`timescale 1ns / 1ps

package sgm_pkg;

    localparam int MAX_WIDTH_DEFAULT = 1024;
    localparam int WIDTH_REG_W = 11;
    localparam int HEIGHT_REG_W = 16;
    localparam int ROW_W = 16;
    localparam int COL_W = 10;
    localparam int PIX_W = 8;
    localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = 11'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd480;
    localparam logic [7:0] MAG_MAX = 8'd255;
    localparam logic [16:0] SUM_CLAMP = 17'd65280;

    localparam logic [0:0] REG_IMAGE_WIDTH = 1'b0;
    localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

    // tdata fields from bit 0: out_row, out_column, out_red, out_green, out_blue
    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
    } result_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_READ  = 5'b00010,
        ST_SQRT  = 5'b00100,
        ST_GRAD  = 5'b01000,
        ST_EDGE  = 5'b10000
    } state_t;

endpackage

@@ rtl/sobel_gradient_magnitude.sv @@
// sobel gradient magnitude top level: line stores, window, isqrt, output
// depends on sgm_pkg
`timescale 1ns / 1ps

// Pixels enter in raster order on s_axis (tdata: red, green, blue from bit 0).
// One pixel is in flight at a time. A pixel with no result takes the input
// transfer and the line-store read-modify-write. A border pixel takes those
// two steps and its output transfer. An interior gradient adds an eight-bit
// square root found one bit per cycle, then the loading of the result and
// its output transfer. A pixel that gives both a gradient and a border
// result adds the border output transfer after that. A result held by a low
// m_axis_tready stalls the block. Results leave on m_axis; tuser carries
// is_gradient, tlast marks the final result caused by an input pixel. Line
// stores need no clearing; image_width and image_height are written on the
// cfg port (index 0 and 1), which is ready only while the block is idle and
// takes priority over a waiting pixel.
module sobel_gradient_magnitude #(
    parameter int MAX_WIDTH = sgm_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // pix_red, pix_green, pix_blue
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // out_row, out_column, out_red, out_green, out_blue
    output logic        m_axis_tuser,   // is_gradient
    output logic        m_axis_tlast,   // last_of_item
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import sgm_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = (AW > WIDTH_REG_W) ? AW + 1 : WIDTH_REG_W + 1;

    logic [7:0] older_mem [MAX_WIDTH];
    logic [7:0] newer_mem [MAX_WIDTH];
    logic [7:0] older_rd, newer_rd;

    state_t state_reg, state_next;
    logic [WIDTH_REG_W-1:0] width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [ROW_W-1:0] row_reg;
    logic [CW-1:0] col_reg;
    logic [7:0] win_reg [3][3];
    logic [23:0] pix_reg;
    logic [AW-1:0] idx_reg;
    logic grad_reg, edge_reg;
    logic [16:0] sum_reg;
    logic [7:0] root_reg;
    logic [3:0] bit_reg;
    logic out_valid_reg, out_user_reg, out_last_reg;
    result_t out_reg;

    logic [CW-1:0] w_eff;
    logic [ROW_W:0] h_eff;
    logic [CW-1:0] idx_full;
    logic [AW-1:0] idx;
    logic accept;
    logic idle;

    assign w_eff = (width_reg == '0) ? CW'(1) :
                   ((CW'(width_reg) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(width_reg));
    assign h_eff = (height_reg == '0) ? 17'd1 : {1'b0, height_reg};
    assign idx_full = (col_reg < CW'(MAX_WIDTH)) ? col_reg : CW'(MAX_WIDTH - 1);
    assign idx = idx_full[AW-1:0];
    assign accept = s_axis_tvalid && s_axis_tready;
    assign idle = (state_reg == ST_IDLE) && !out_valid_reg;
    assign s_axis_tready = idle && !cfg_valid;
    assign cfg_ready = idle;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            older_rd <= older_mem[idx];
            newer_rd <= newer_mem[idx];
        end
        if (state_reg == ST_READ)
        begin
            older_mem[idx_reg] <= newer_rd;
            newer_mem[idx_reg] <= pix_reg[7:0];
        end
    end

    // kernel sums on the shifted window
    logic [7:0] nw [3][3];
    logic signed [11:0] gx, gy;
    logic signed [23:0] gx_sq, gy_sq;
    logic [21:0] gx2, gy2;
    logic [22:0] s_full;
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nw[i][0] = win_reg[i][1];
            nw[i][1] = win_reg[i][2];
        end
        nw[0][2] = older_rd;
        nw[1][2] = newer_rd;
        nw[2][2] = pix_reg[7:0];
        gx = 12'(nw[0][2]) + 12'(2 * nw[1][2]) + 12'(nw[2][2])
           - 12'(nw[0][0]) - 12'(2 * nw[1][0]) - 12'(nw[2][0]);
        gy = 12'(nw[2][0]) + 12'(2 * nw[2][1]) + 12'(nw[2][2])
           - 12'(nw[0][0]) - 12'(2 * nw[0][1]) - 12'(nw[0][2]);
        gx_sq = 24'(gx) * 24'(gx);
        gy_sq = 24'(gy) * 24'(gy);
        gx2 = gx_sq[21:0];
        gy2 = gy_sq[21:0];
        s_full = 23'(gx2) + 23'(gy2);
    end

    logic [7:0] trial;
    logic [15:0] trial_sq;
    logic [7:0] mag;
    logic [16:0] rnd;
    always_comb
    begin
        trial = root_reg | (8'd1 << bit_reg[2:0]);
        trial_sq = trial * trial;
        rnd = 17'(root_reg) * 17'(root_reg) + 17'(root_reg);
        if (sum_reg > SUM_CLAMP)
            mag = MAG_MAX;
        else if (sum_reg > rnd)
            mag = root_reg + 8'd1;
        else
            mag = root_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_READ;
            ST_READ: state_next = grad_reg ? ST_SQRT : ST_IDLE;
            ST_SQRT: if (bit_reg == 4'd0) state_next = ST_GRAD;
            ST_GRAD: if (!out_valid_reg) state_next = edge_reg ? ST_EDGE : ST_IDLE;
            ST_EDGE: if (!out_valid_reg) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            width_reg <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            row_reg <= '0;
            col_reg <= '0;
            out_valid_reg <= 1'b0;
            out_user_reg <= 1'b0;
            out_last_reg <= 1'b0;
            out_reg <= '0;
            pix_reg <= '0;
            idx_reg <= '0;
            grad_reg <= 1'b0;
            edge_reg <= 1'b0;
            sum_reg <= '0;
            root_reg <= '0;
            bit_reg <= '0;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    win_reg[i][j] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_IMAGE_WIDTH)
                    width_reg <= cfg_data[WIDTH_REG_W-1:0];
                else
                    height_reg <= cfg_data;
            end
            if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        pix_reg <= s_axis_tdata;
                        idx_reg <= idx;
                        grad_reg <= (row_reg >= 16'd2) && (col_reg >= CW'(2))
                                    && ({1'b0, row_reg} < h_eff) && (col_reg < w_eff);
                        edge_reg <= (row_reg == '0) || ({1'b0, row_reg} + 17'd1 >= h_eff)
                                    || (col_reg == '0) || (col_reg + CW'(1) >= w_eff);
                    end
                end
                ST_READ:
                begin
                    for (int i = 0; i < 3; i++)
                        for (int j = 0; j < 3; j++)
                            win_reg[i][j] <= nw[i][j];
                    sum_reg <= (s_full > 23'(SUM_CLAMP)) ? SUM_CLAMP + 17'd1 : s_full[16:0];
                    root_reg <= '0;
                    bit_reg <= 4'd7;
                    out_reg <= {pix_reg[23:16], pix_reg[15:8], pix_reg[7:0],
                                col_reg[COL_W-1:0], row_reg};
                    if (col_reg + CW'(1) >= w_eff)
                    begin
                        col_reg <= '0;
                        row_reg <= ({1'b0, row_reg} + 17'd1 >= h_eff) ? '0 : row_reg + 16'd1;
                    end
                    else
                        col_reg <= col_reg + CW'(1);
                    if (!grad_reg && edge_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        out_user_reg <= 1'b0;
                        out_last_reg <= 1'b1;
                    end
                end
                ST_SQRT:
                begin
                    if ({1'b0, trial_sq} <= sum_reg)
                        root_reg <= trial;
                    bit_reg <= bit_reg - 4'd1;
                end
                ST_GRAD:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        out_user_reg <= 1'b1;
                        out_last_reg <= !edge_reg;
                        out_reg.row <= out_reg.row - 16'd1;
                        out_reg.column <= out_reg.column - 10'd1;
                        out_reg.red <= mag;
                        out_reg.green <= mag;
                        out_reg.blue <= mag;
                        pix_reg <= {out_reg.blue, out_reg.green, out_reg.red};
                    end
                end
                ST_EDGE:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        out_user_reg <= 1'b0;
                        out_last_reg <= 1'b1;
                        out_reg.row <= out_reg.row + 16'd1;
                        out_reg.column <= out_reg.column + 10'd1;
                        out_reg.red <= pix_reg[7:0];
                        out_reg.green <= pix_reg[15:8];
                        out_reg.blue <= pix_reg[23:16];
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {6'b0, out_reg};
    assign m_axis_tuser = out_user_reg;
    assign m_axis_tlast = out_last_reg;

endmodule
